FILE: design/iira_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed insert/remove array - shared definitions
// Sizes, field widths, status codes and the per-cell control word.
// ----------------------------------------------------------------------------
package iira_pkg;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned INDEX_W     = 5;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_OUT_W = 5;

  // Fill count holds 0 to DEPTH; comparisons run at the wider of count and index.
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W  = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  // Maximum tree: levels and padded leaf count.
  localparam int unsigned LVLS   = $clog2(DEPTH);
  localparam int unsigned LEAVES = 1 << LVLS;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd3;

  // What a cell loads at the next edge.
  typedef enum logic [1:0] {
    SEL_HOLD,
    SEL_LOAD,
    SEL_LOWER,
    SEL_UPPER
  } iira_sel_e;

  typedef struct packed {
    iira_sel_e         sel;
    logic [WORD_W-1:0] word;
  } iira_cell_ctrl_t;

endpackage

FILE: design/iira_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed insert/remove array - storage cell
// Holds one entry; loads the new word or takes its lower or upper neighbour.
// ----------------------------------------------------------------------------
module iira_cell (
  input  logic                                clk_i,
  input  iira_pkg::iira_cell_ctrl_t           ctrl_i,
  input  logic [iira_pkg::WORD_W-1:0]         lower_i,
  input  logic [iira_pkg::WORD_W-1:0]         upper_i,
  output logic [iira_pkg::WORD_W-1:0]         entry_o
);

  logic [iira_pkg::WORD_W-1:0] entry_q, entry_d;

  always_comb begin
    unique case (ctrl_i.sel)
      iira_pkg::SEL_HOLD:  entry_d = entry_q;
      iira_pkg::SEL_LOAD:  entry_d = ctrl_i.word;
      iira_pkg::SEL_LOWER: entry_d = lower_i;
      iira_pkg::SEL_UPPER: entry_d = upper_i;
      default:             entry_d = entry_q;
    endcase
  end

  // Payload only: contents are undefined until written.
  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: design/iira_max_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed insert/remove array - maximum tree
// Registered binary tree giving the largest valid leaf, one level per cycle.
// ----------------------------------------------------------------------------
module iira_max_tree (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic [iira_pkg::DEPTH-1:0]                     leaf_valid_i,
  input  logic [iira_pkg::DEPTH-1:0][iira_pkg::WORD_W-1:0] leaf_word_i,
  output logic                                           root_valid_o,
  output logic [iira_pkg::WORD_W-1:0]                    root_word_o
);

  localparam int unsigned LEAVES = iira_pkg::LEAVES;
  localparam int unsigned WORD_W = iira_pkg::WORD_W;

  logic              leaf_v [LEAVES];
  logic [WORD_W-1:0] leaf_w [LEAVES];

  // Heap layout: node k has children 2k and 2k+1; the root is node 1.
  logic              node_v_q [1:LEAVES-1];
  logic [WORD_W-1:0] node_w_q [1:LEAVES-1];

  for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
    if (j < iira_pkg::DEPTH) begin : g_real
      assign leaf_v[j] = leaf_valid_i[j];
      assign leaf_w[j] = leaf_word_i[j];
    end else begin : g_pad
      assign leaf_v[j] = 1'b0;
      assign leaf_w[j] = '0;
    end
  end

  for (genvar k = 1; k < LEAVES; k++) begin : g_node
    logic              a_v, b_v;
    logic [WORD_W-1:0] a_w, b_w;
    logic              take_a;

    if (2 * k >= LEAVES) begin : g_from_leaf
      assign a_v = leaf_v[2*k-LEAVES];
      assign a_w = leaf_w[2*k-LEAVES];
      assign b_v = leaf_v[2*k+1-LEAVES];
      assign b_w = leaf_w[2*k+1-LEAVES];
    end else begin : g_from_node
      assign a_v = node_v_q[2*k];
      assign a_w = node_w_q[2*k];
      assign b_v = node_v_q[2*k+1];
      assign b_w = node_w_q[2*k+1];
    end

    assign take_a = a_v && (!b_v || ($signed(a_w) >= $signed(b_w)));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        node_v_q[k] <= 1'b0;
      end else begin
        node_v_q[k] <= a_v | b_v;
      end
    end

    always_ff @(posedge clk_i) begin
      node_w_q[k] <= take_a ? a_w : b_w;
    end
  end

  assign root_valid_o = node_v_q[1];
  assign root_word_o  = node_w_q[1];

endmodule

FILE: design/indexed_insert_remove_array_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed insert/remove array - top level
// Ordered array of signed words with insert-at-index and remove-at-index.
// ----------------------------------------------------------------------------
// Each input transfer either inserts a word at a position (later entries move
// up by one place) or removes the entry at a position (later entries move down
// by one place); every transfer yields exactly one result carrying the status,
// the fill count and the largest stored word. The entries live in a row of
// cells that all shift in the same cycle. The largest word comes from a
// registered tree over the cells, one level per cycle; an item passes
// through the accepting edge, $clog2(DEPTH) tree levels and the load of the
// output register, which waits while an earlier result is still untaken. The
// input is ready again as soon as the result sits in the output register,
// even if it has not yet been taken. A failed request (bad position, insert
// into a full array, remove from an empty one) leaves the contents untouched
// and reports the error in the status field.
// ----------------------------------------------------------------------------
module indexed_insert_remove_array_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [4:0] index, [36:5] value, [39:37] zero
  input  logic [iira_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [0] mode
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [1:0] status, [6:2] count, [38:7] max_value, [39] max_valid
  output logic [iira_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

  localparam int unsigned DEPTH  = iira_pkg::DEPTH;
  localparam int unsigned WORD_W = iira_pkg::WORD_W;
  localparam int unsigned CNT_W  = iira_pkg::CNT_W;
  localparam int unsigned CMP_W  = iira_pkg::CMP_W;
  localparam int unsigned LVLS   = iira_pkg::LVLS;
  localparam int unsigned WAIT_W = $clog2(LVLS + 1);

  // Controller states.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CALC = 1'b1;

  logic state_q, state_d;
  logic [WAIT_W-1:0] wait_q, wait_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [iira_pkg::STATUS_W-1:0] status_q, status_d;

  logic out_valid_q, out_valid_d;
  logic [iira_pkg::OUT_DATA_W-1:0] out_data_q;

  // Unpack the input transfer.
  logic                        in_mode;
  logic [iira_pkg::INDEX_W-1:0] in_index;
  logic [WORD_W-1:0]           in_value;

  assign in_mode  = s_axis_tuser;
  assign in_index = s_axis_tdata[iira_pkg::INDEX_W-1:0];
  assign in_value = s_axis_tdata[iira_pkg::INDEX_W +: WORD_W];

  logic accept;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Request check. A bad position on insert wins over a full array; on remove
  // the empty check comes first.
  logic [CMP_W-1:0] pos_ext, cnt_ext;
  logic [iira_pkg::STATUS_W-1:0] req_status;

  assign pos_ext = CMP_W'(in_index);
  assign cnt_ext = CMP_W'(count_q);

  always_comb begin
    req_status = iira_pkg::STATUS_OK;
    if (in_mode == iira_pkg::MODE_INSERT) begin
      if (pos_ext > cnt_ext) begin
        req_status = iira_pkg::STATUS_RANGE;
      end else if (count_q == CNT_W'(DEPTH)) begin
        req_status = iira_pkg::STATUS_FULL;
      end
    end else begin
      if (count_q == '0) begin
        req_status = iira_pkg::STATUS_EMPTY;
      end else if (pos_ext >= cnt_ext) begin
        req_status = iira_pkg::STATUS_RANGE;
      end
    end
  end

  logic do_insert, do_remove;
  assign do_insert = accept && (req_status == iira_pkg::STATUS_OK) &&
                     (in_mode == iira_pkg::MODE_INSERT);
  assign do_remove = accept && (req_status == iira_pkg::STATUS_OK) &&
                     (in_mode == iira_pkg::MODE_REMOVE);

  // Cell controls: on insert, cells above the position take their lower
  // neighbour and the cell at the position loads the word; on remove, cells
  // from the position up to the one below the top take their upper neighbour.
  iira_pkg::iira_cell_ctrl_t ctrl [DEPTH];
  logic [DEPTH-1:0][WORD_W-1:0] entries;
  logic [DEPTH-1:0] leaf_valid;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ctrl[i].word = in_value;
      ctrl[i].sel  = iira_pkg::SEL_HOLD;
      if (do_insert) begin
        if (CMP_W'(i) > pos_ext) begin
          ctrl[i].sel = iira_pkg::SEL_LOWER;
        end else if (CMP_W'(i) == pos_ext) begin
          ctrl[i].sel = iira_pkg::SEL_LOAD;
        end
      end else if (do_remove) begin
        if ((CMP_W'(i) >= pos_ext) && (i < DEPTH - 1)) begin
          ctrl[i].sel = iira_pkg::SEL_UPPER;
        end
      end
      leaf_valid[i] = (CMP_W'(i) < cnt_ext);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] lower, upper;
    if (i == 0) begin : g_bottom
      assign lower = '0;
    end else begin : g_lower
      assign lower = entries[i-1];
    end
    if (i == DEPTH - 1) begin : g_top
      assign upper = '0;
    end else begin : g_upper
      assign upper = entries[i+1];
    end

    iira_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[i]),
      .lower_i (lower),
      .upper_i (upper),
      .entry_o (entries[i])
    );
  end

  logic              root_valid;
  logic [WORD_W-1:0] root_word;

  iira_max_tree u_max_tree (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .leaf_valid_i (leaf_valid),
    .leaf_word_i  (entries),
    .root_valid_o (root_valid),
    .root_word_o  (root_word)
  );

  // The tree root reflects the new contents once every level has been refreshed.
  logic calc_done, load_out;
  assign calc_done = (wait_q == WAIT_W'(LVLS));
  assign load_out  = (state_q == ST_CALC) && calc_done &&
                     (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d  = state_q;
    wait_d   = wait_q;
    count_d  = count_q;
    status_d = status_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d  = ST_CALC;
          wait_d   = '0;
          status_d = req_status;
          if (do_insert) begin
            count_d = count_q + 1'b1;
          end else if (do_remove) begin
            count_d = count_q - 1'b1;
          end
        end
      end
      ST_CALC: begin
        if (!calc_done) begin
          wait_d = wait_q + 1'b1;
        end
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output register: result fields packed from the lowest bit up.
  logic [CMP_W-1:0]              count_wide;
  logic [iira_pkg::OUT_DATA_W-1:0] result;
  assign count_wide = CMP_W'(count_q);
  assign result = {root_valid,
                   (root_valid ? root_word : {WORD_W{1'b0}}),
                   count_wide[iira_pkg::COUNT_OUT_W-1:0],
                   status_q};

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wait_q      <= '0;
      count_q     <= '0;
      status_q    <= iira_pkg::STATUS_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wait_q      <= wait_d;
      count_q     <= count_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // The fill count never passes the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("fill count above capacity");

  // A remove from an empty array is reported as such.
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_mode == iira_pkg::MODE_REMOVE) && (count_q == '0))
    |=> (status_q == iira_pkg::STATUS_EMPTY))
    else $error("remove from empty array not flagged");

  // A successful insert grows the count by exactly one.
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_insert |=> (count_q == CNT_W'($past(count_q) + 1'b1)))
    else $error("insert did not advance fill count");

  // When the result is captured the tree has caught up with the contents.
  a_tree_settled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (root_valid == (count_q != '0)))
    else $error("maximum tree not settled at result capture");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Indexed insert/remove array - testbench
// Drives insert and remove transfers into the block, keeps its own copy of
// the array to predict status, count and largest word for each transfer, and
// compares every result field by field. Both stream sides stall at random, apart from a back-to-back stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import iira_pkg::*;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = LVLS + 8;

  // One result as it sits on m_axis_tdata, highest field first.
  typedef struct packed {
    logic                     max_valid;
    logic signed [WORD_W-1:0] max_value;
    logic [COUNT_OUT_W-1:0]   count;
    logic [STATUS_W-1:0]      status;
  } array_result_t;

  logic                  clk_i;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = MODE_INSERT;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Shadow of the array contents and fill count.
  logic signed [WORD_W-1:0] shadow_entries [DEPTH];
  int unsigned              shadow_fill;

  array_result_t expected_q[$];
  int unsigned   tx_idle_pct   = 32;
  int unsigned   rx_idle_pct   = 32;
  int unsigned   fail_count    = 0;
  int unsigned   stall_cycles  = 0;
  int unsigned   insert_tally  = 0;
  int unsigned   remove_tally  = 0;
  int unsigned   status_tally [4];

  indexed_insert_remove_array_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Applies one operation to the shadow array and returns the result the
  // block should give for it.
  function automatic array_result_t apply_array_op(input logic op,
                                                   input logic [INDEX_W-1:0] pos,
                                                   input logic [WORD_W-1:0] word);
    array_result_t            res;
    logic signed [WORD_W-1:0] best;
    res.status = STATUS_OK;
    if (op == MODE_INSERT) begin
      if (pos > shadow_fill) begin
        res.status = STATUS_RANGE;
      end else if (shadow_fill >= DEPTH) begin
        res.status = STATUS_FULL;
      end else begin
        for (int i = int'(shadow_fill); i > int'(pos); i--) begin
          shadow_entries[i] = shadow_entries[i-1];
        end
        shadow_entries[pos] = word;
        shadow_fill++;
      end
    end else begin
      if (shadow_fill == 0) begin
        res.status = STATUS_EMPTY;
      end else if (pos >= shadow_fill) begin
        res.status = STATUS_RANGE;
      end else begin
        for (int i = int'(pos); i + 1 < int'(shadow_fill); i++) begin
          shadow_entries[i] = shadow_entries[i+1];
        end
        shadow_fill--;
      end
    end
    best = '0;
    if (shadow_fill != 0) begin
      best = shadow_entries[0];
      for (int i = 1; i < int'(shadow_fill); i++) begin
        if (shadow_entries[i] > best) best = shadow_entries[i];
      end
    end
    res.count     = COUNT_OUT_W'(shadow_fill);
    res.max_value = best;
    res.max_valid = (shadow_fill != 0);
    return res;
  endfunction

  // Mostly random words, with the extremes and small values near zero mixed
  // in so that ties and sign changes of the largest word turn up often.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      4:       return WORD_W'($urandom_range(0, 15)) - 32'd8;
      default: return $urandom();
    endcase
  endfunction

  // Position for the next operation: usually a legal one, now and then any
  // value the five-bit field can hold.
  function automatic logic [INDEX_W-1:0] pick_position(input logic op);
    if ($urandom_range(0, 99) < 12 || (op == MODE_REMOVE && shadow_fill == 0)) begin
      return INDEX_W'($urandom_range(0, 31));
    end
    if (op == MODE_INSERT) return INDEX_W'($urandom_range(0, shadow_fill));
    return INDEX_W'($urandom_range(0, shadow_fill - 1));
  endfunction

  // Presents one item, waits for its transfer and records the prediction.
  // The valid stays high into the next call unless that call opens a gap.
  task automatic send_item(input logic op, input logic [INDEX_W-1:0] pos,
                           input logic [WORD_W-1:0] word);
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {{(IN_DATA_W - INDEX_W - WORD_W){1'b0}}, word, pos};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_q.push_back(apply_array_op(op, pos, word));
    if (op == MODE_INSERT) insert_tally++;
    else remove_tally++;
  endtask

  // Errors on an empty array, positions past the count, appends, inserts and
  // removes at the front, middle and end, and the extreme words.
  task automatic test_edge_cases();
    send_item(MODE_REMOVE, 5'd0, $urandom());
    send_item(MODE_REMOVE, 5'd31, $urandom());
    send_item(MODE_INSERT, 5'd1, 32'h1234_5678);
    send_item(MODE_INSERT, 5'd31, 32'h1234_5678);
    send_item(MODE_INSERT, 5'd0, 32'h8000_0000);
    send_item(MODE_INSERT, 5'd1, 32'h7fff_ffff);
    send_item(MODE_INSERT, 5'd0, 32'hffff_ffff);
    send_item(MODE_INSERT, 5'd1, 32'h0000_0000);
    send_item(MODE_INSERT, 5'd5, 32'h5555_5555);
    send_item(MODE_REMOVE, 5'd4, $urandom());
    send_item(MODE_REMOVE, 5'd3, $urandom());
    send_item(MODE_REMOVE, 5'd0, $urandom());
    send_item(MODE_INSERT, 5'd2, 32'h0000_0001);
    send_item(MODE_REMOVE, 5'd1, $urandom());
    send_item(MODE_REMOVE, 5'd16, $urandom());
    send_item(MODE_REMOVE, 5'd0, $urandom());
    send_item(MODE_REMOVE, 5'd0, $urandom());
    send_item(MODE_REMOVE, 5'd0, $urandom());
  endtask

  // Fills the array to the brim at random positions, tries to overfill it
  // with good and bad positions, then empties it again.
  task automatic test_fill_and_drain();
    while (shadow_fill < DEPTH) begin
      send_item(MODE_INSERT, INDEX_W'($urandom_range(0, shadow_fill)), pick_word());
    end
    send_item(MODE_INSERT, INDEX_W'($urandom_range(0, DEPTH - 1)), pick_word());
    send_item(MODE_INSERT, INDEX_W'(DEPTH), pick_word());
    send_item(MODE_INSERT, INDEX_W'(DEPTH + 1), pick_word());
    send_item(MODE_INSERT, 5'd31, pick_word());
    send_item(MODE_REMOVE, INDEX_W'(DEPTH), $urandom());
    while (shadow_fill != 0) begin
      send_item(MODE_REMOVE, INDEX_W'($urandom_range(0, shadow_fill - 1)), $urandom());
    end
    send_item(MODE_REMOVE, INDEX_W'($urandom_range(0, 31)), $urandom());
  endtask

  // Random traffic; insert_pct steers the fill level up or down.
  task automatic test_random_traffic(input int unsigned n_items,
                                     input int unsigned insert_pct);
    logic op;
    repeat (n_items) begin
      op = ($urandom_range(0, 99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
      send_item(op, pick_position(op), (op == MODE_INSERT) ? pick_word() : $urandom());
    end
  endtask

  // A long stretch with both sides always willing, so that items go back to
  // back at the block's own pace.
  task automatic test_back_to_back();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_traffic(200, 55);
    tx_idle_pct = 32;
    rx_idle_pct = 32;
  endtask

  // The receiver stalls at random, except while rx_idle_pct is zero.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // Compares every result transfer with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    array_result_t got;
    array_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = array_result_t'(m_axis_tdata);
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, got %h", $time, m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        status_tally[want.status]++;
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
          fail_count++;
        end
        if (got.count !== want.count) begin
          $display("%0t: count expected %0d, actual %0d", $time, want.count, got.count);
          fail_count++;
        end
        if (got.max_value !== want.max_value) begin
          $display("%0t: max_value expected %0d, actual %0d", $time, want.max_value,
                   got.max_value);
          fail_count++;
        end
        if (got.max_valid !== want.max_valid) begin
          $display("%0t: max_valid expected %0d, actual %0d", $time, want.max_valid,
                   got.max_valid);
          fail_count++;
        end
      end
    end
  end

  // Ends the run if no transfer happens on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    shadow_fill = 0;
    foreach (shadow_entries[i]) shadow_entries[i] = '0;
    foreach (status_tally[i]) status_tally[i] = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_cases();
    test_fill_and_drain();
    test_random_traffic(300, 70);
    test_random_traffic(300, 30);
    test_back_to_back();
    test_random_traffic(200, 50);

    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d inserts and %0d removes; results ok %0d, bad position %0d,",
             insert_tally, remove_tally, status_tally[STATUS_OK], status_tally[STATUS_RANGE]);
    $display("full %0d, empty %0d; %0d field mismatches.",
             status_tally[STATUS_FULL], status_tally[STATUS_EMPTY], fail_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: files.f
design/iira_pkg.sv
design/iira_cell.sv
design/iira_max_tree.sv
design/indexed_insert_remove_array_top.sv
tb/tb_top.sv
